// ===== rtl/cmks_pkg.sv =====
// Package with shared types and constants for the cost matrix sparsifier.
`timescale 1ns / 1ps
package cmks_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int COST_W = 31;
    localparam int CFG_W = 7;
    localparam logic CFG_SIZE = 1'b0;
    localparam logic CFG_KEEP = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_VREAD,
        ST_VLAT,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_step;
        logic v_latch;
        logic scan_issue;
        logic decide;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic load_last;
        logic m_last;
        logic j_last;
        logic out_free;
    } sts_t;
endpackage

// ===== rtl/cost_matrix_knn_sparsify_core.sv =====
// Top level of the k-nearest-neighbor cost matrix sparsifier.
// The block loads an N by N matrix of costs in row-major order, one beat per cycle.
// After the last beat it ranks every entry against its row and its column, one
// pair of memory reads per cycle from a dual-read cost memory; a stalled row mask
// holds the ranking until it is taken. One keep mask per row leaves as it
// completes, and loading of the next matrix starts after the last row mask is
// registered. A configuration write returns the load position to the first entry.
`timescale 1ns / 1ps
module cost_matrix_knn_sparsify_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [cmks_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // cost[30:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [71:0]                       m_tdata,  // row_index[5:0], keep_mask[69:6]
    output logic                              m_tlast
);
    import cmks_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [IDX_W-1:0] row;
    logic [MAX_POINTS-1:0] mask;

    cmks_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    cmks_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_cost(s_tdata[COST_W-1:0]), .cmd(cmd), .sts(sts),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_row(row), .m_mask(mask),
        .m_last(m_tlast)
    );

    assign m_tdata = {2'b00, mask, row};

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> sts.out_free) else $error("Row mask emitted over a pending beat.");
    a_no_scan_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.scan_issue && !cmd.decide) else $error("Scan during load.");
    a_decide_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |=> !cmd.decide && !cmd.scan_issue) else $error("Decide not followed.");
endmodule

// ===== rtl/cmks_ctrl.sv =====
// Controller state machine that sequences loading, ranking and mask output.
`timescale 1ns / 1ps
module cmks_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  cmks_pkg::sts_t sts,
    output cmks_pkg::cmd_t cmd
);
    import cmks_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load_step = s_tvalid;
                if (s_tvalid && sts.load_last) state_next = ST_VREAD;
            end
            ST_VREAD: state_next = ST_VLAT;
            ST_VLAT: begin
                cmd.v_latch = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.m_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_DECIDE;
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = sts.j_last ? ST_EMIT : ST_VREAD;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = sts.load_last ? ST_LOAD : ST_VREAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end
endmodule

// ===== rtl/cmks_dp.sv =====
// Datapath with the cost memory, index counters, rank counters and output register.
`timescale 1ns / 1ps
module cmks_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [cmks_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic [cmks_pkg::COST_W-1:0]           s_cost,
    input  cmks_pkg::cmd_t                        cmd,
    output cmks_pkg::sts_t                        sts,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [cmks_pkg::IDX_W-1:0]            m_row,
    output logic [cmks_pkg::MAX_POINTS-1:0]       m_mask,
    output logic                                  m_last
);
    import cmks_pkg::*;

    logic [CFG_W-1:0] size_reg, keep_reg;
    logic [CNT_W-1:0] n_eff, k_eff;
    logic [IDX_W-1:0] nm1;
    logic [IDX_W-1:0] lr_reg, lc_reg, i_reg, j_reg, m_reg, pm_reg;
    logic pend_reg;
    logic [COST_W-1:0] mem [MAX_POINTS*MAX_POINTS];
    logic [COST_W-1:0] rda_reg, rdb_reg, v_reg;
    logic [ADDR_W-1:0] addra;
    logic [CNT_W-1:0] rrank_reg, crank_reg;
    logic [MAX_POINTS-1:0] mask_reg;
    logic out_valid_reg, out_last_reg;
    logic [IDX_W-1:0] out_row_reg;
    logic [MAX_POINTS-1:0] out_mask_reg;
    logic a_less, b_less;

    always_comb begin
        if (size_reg == '0) n_eff = CNT_W'(1);
        else if (size_reg > CFG_W'(MAX_POINTS)) n_eff = CNT_W'(MAX_POINTS);
        else n_eff = CNT_W'(size_reg);
        k_eff = (CNT_W'(keep_reg) < n_eff) ? CNT_W'(keep_reg) : n_eff;
        nm1 = IDX_W'(n_eff - CNT_W'(1));
    end

    assign sts.load_last = cmd.emit ? (i_reg == nm1) : (lr_reg == nm1 && lc_reg == nm1);
    assign sts.m_last = (m_reg == nm1);
    assign sts.j_last = (j_reg == nm1);
    assign sts.out_free = !out_valid_reg || m_tready;
    assign addra = cmd.scan_issue ? {i_reg, m_reg} : {i_reg, j_reg};
    assign a_less = (rda_reg < v_reg) || (rda_reg == v_reg && pm_reg < j_reg);
    assign b_less = (rdb_reg < v_reg) || (rdb_reg == v_reg && pm_reg < i_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_step) mem[{lr_reg, lc_reg}] <= s_cost;
        rda_reg <= mem[addra];
        rdb_reg <= mem[{m_reg, j_reg}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= CFG_W'(MAX_POINTS);
            keep_reg <= CFG_W'(8);
            lr_reg <= '0;
            lc_reg <= '0;
            pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_SIZE) size_reg <= cfg_wdata;
                else keep_reg <= cfg_wdata;
                lr_reg <= '0;
                lc_reg <= '0;
            end else if (cmd.load_step) begin
                if (lc_reg == nm1) begin
                    lc_reg <= '0;
                    lr_reg <= (lr_reg == nm1) ? '0 : lr_reg + 1'b1;
                end else begin
                    lc_reg <= lc_reg + 1'b1;
                end
            end
            pend_reg <= cmd.scan_issue;
            if (cmd.emit) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        pm_reg <= m_reg;
        if (cmd.load_step || cmd.emit) begin
            i_reg <= cmd.emit ? i_reg + 1'b1 : '0;
            j_reg <= '0;
            mask_reg <= '0;
        end
        if (cmd.v_latch) begin
            v_reg <= rda_reg;
            m_reg <= '0;
            rrank_reg <= '0;
            crank_reg <= '0;
        end
        if (cmd.scan_issue) m_reg <= m_reg + 1'b1;
        if (pend_reg) begin
            rrank_reg <= rrank_reg + CNT_W'(a_less);
            crank_reg <= crank_reg + CNT_W'(b_less);
        end
        if (cmd.decide) begin
            mask_reg[j_reg] <= (rrank_reg < k_eff) || (crank_reg < k_eff);
            if (j_reg != nm1) j_reg <= j_reg + 1'b1;
        end
        if (cmd.emit) begin
            out_row_reg <= i_reg;
            out_mask_reg <= mask_reg;
            out_last_reg <= (i_reg == nm1);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_row = out_row_reg;
    assign m_mask = out_mask_reg;
    assign m_last = out_last_reg;
endmodule
